// ===== rtl/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg: shared types and helpers of the pixel format converter
// Format codes, configuration register indexes, stage payload structs and the
// fixed-point clamp used by the colour-space stage.
// ----------------------------------------------------------------------------
package pfc_pkg;

   localparam int PIX_W  = 8;   // one colour byte
   localparam int FMT_W  = 3;   // format code width
   localparam int CNT_W  = 3;   // output byte count width
   localparam int TERM_W = 16;  // signed chroma product
   localparam int SUM_W  = 17;  // luma * 64 plus chroma product
   localparam int PROD_W = 14;  // gray weighting product

   typedef enum logic [FMT_W-1:0] {
      FMT_RGBA = 3'd0,
      FMT_BGRA = 3'd1,
      FMT_RGB  = 3'd2,
      FMT_BGR  = 3'd3,
      FMT_GRAY = 3'd4,
      FMT_YUV  = 3'd5
   } fmt_type;

   typedef enum logic {
      CSR_SRC_FORMAT = 1'b0,
      CSR_DST_FORMAT = 1'b1
   } csr_index_type;

   localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'd255;

   typedef struct packed {
      logic             ok;
      logic [CNT_W-1:0] channels;
      logic [FMT_W-1:0] dst;
      logic             gray_copy;  // gray output takes chan0 directly
      logic             is_yuv;
      logic             last;
   } ctrl_type;

   typedef struct packed {
      ctrl_type                  ctrl;
      logic [PIX_W-1:0]          r;
      logic [PIX_W-1:0]          g;
      logic [PIX_W-1:0]          b;
      logic [PIX_W-1:0]          a;
      logic [PIX_W-1:0]          c0;
      logic signed [TERM_W-1:0]  term_r;
      logic signed [TERM_W-1:0]  term_g;
      logic signed [TERM_W-1:0]  term_b;
   } s1_type;

   typedef struct packed {
      ctrl_type          ctrl;
      logic [PIX_W-1:0]  r;
      logic [PIX_W-1:0]  g;
      logic [PIX_W-1:0]  b;
      logic [PIX_W-1:0]  a;
      logic [PIX_W-1:0]  c0;
      logic [PROD_W-1:0] prod_r;
      logic [PROD_W-1:0] prod_g;
      logic [PROD_W-1:0] prod_b;
   } s2_type;

   // floor(x / 64), clamped to 0..255
   function automatic logic [PIX_W-1:0] shift_clamp(input logic signed [SUM_W-1:0] x);
      logic signed [SUM_W-7:0] q;
      q = x[SUM_W-1:6];
      if (q < 0) begin
         return '0;
      end else if (q > 255) begin
         return 8'd255;
      end
      return q[PIX_W-1:0];
   endfunction

endpackage

// ===== rtl/pfc_unpack.sv =====
// ----------------------------------------------------------------------------
// pfc_unpack: first pipeline stage
// Decodes the format pair, unpacks source bytes into R, G, B, A and forms
// the signed chroma products for YUV sources.
// ----------------------------------------------------------------------------
module pfc_unpack (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [2:0]             src_format,
   input  logic [2:0]             dst_format,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [7:0]             chan0,
   input  logic [7:0]             chan1,
   input  logic [7:0]             chan2,
   input  logic [7:0]             chan3,
   input  logic                   last_pixel,
   output logic                   out_valid,
   input  logic                   out_ready,
   output pfc_pkg::s1_type        out_data
);
   import pfc_pkg::*;

   logic                     valid_ff, valid_in;
   s1_type                   data_ff, data_in;
   logic                     src_ok, four_in;
   logic signed [PIX_W-1:0]  u_s, v_s;

   // chroma minus 128 is the byte with its top bit inverted
   assign v_s = {~chan1[7], chan1[6:0]};
   assign u_s = {~chan2[7], chan2[6:0]};

   always_comb begin
      data_in        = '0;
      src_ok         = 1'b1;
      four_in        = 1'b0;
      data_in.c0     = chan0;
      unique case (src_format)
         FMT_RGBA: begin
            data_in.r = chan0; data_in.g = chan1; data_in.b = chan2;
            data_in.a = chan3; four_in = 1'b1;
         end
         FMT_BGRA: begin
            data_in.r = chan2; data_in.g = chan1; data_in.b = chan0;
            data_in.a = chan3; four_in = 1'b1;
         end
         FMT_RGB: begin
            data_in.r = chan0; data_in.g = chan1; data_in.b = chan2;
         end
         FMT_BGR: begin
            data_in.r = chan2; data_in.g = chan1; data_in.b = chan0;
         end
         FMT_GRAY: begin
            data_in.r = chan0; data_in.g = chan0; data_in.b = chan0;
            data_in.a = ALPHA_OPAQUE; four_in = 1'b1;
         end
         FMT_YUV: begin
            data_in.a = ALPHA_OPAQUE; four_in = 1'b1;
         end
         default: begin
            src_ok = 1'b0;
         end
      endcase

      data_in.term_r = TERM_W'(v_s) * 16'sd73;
      data_in.term_g = -(TERM_W'(u_s) * 16'sd25 + TERM_W'(v_s) * 16'sd37);
      data_in.term_b = TERM_W'(u_s) * 16'sd130;

      data_in.ctrl.ok        = src_ok;
      data_in.ctrl.channels  = '0;
      data_in.ctrl.dst       = dst_format;
      data_in.ctrl.gray_copy = (src_format == FMT_GRAY) || (src_format == FMT_YUV);
      data_in.ctrl.is_yuv    = (src_format == FMT_YUV);
      data_in.ctrl.last      = last_pixel;
      unique case (dst_format)
         FMT_RGBA, FMT_BGRA: begin
            data_in.ctrl.channels = 3'd4;
            if (!four_in) begin
               data_in.ctrl.ok = 1'b0;
            end
         end
         FMT_RGB, FMT_BGR: data_in.ctrl.channels = 3'd3;
         FMT_GRAY:         data_in.ctrl.channels = 3'd1;
         default:          data_in.ctrl.ok       = 1'b0;
      endcase
      if (!data_in.ctrl.ok) begin
         data_in.ctrl.channels = '0;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/pfc_colour.sv =====
// ----------------------------------------------------------------------------
// pfc_colour: second pipeline stage
// Sums luma and chroma terms, shifts and clamps for YUV sources, and forms
// the weighted products for gray output from colour sources.
// ----------------------------------------------------------------------------
module pfc_colour (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  pfc_pkg::s1_type    in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output pfc_pkg::s2_type    out_data
);
   import pfc_pkg::*;

   logic                    valid_ff, valid_in;
   s2_type                  data_ff, data_in;
   logic signed [SUM_W-1:0] y64, sum_r, sum_g, sum_b;

   assign y64   = $signed({3'b000, in_data.c0, 6'b000000});
   assign sum_r = y64 + SUM_W'(in_data.term_r);
   assign sum_g = y64 + SUM_W'(in_data.term_g);
   assign sum_b = y64 + SUM_W'(in_data.term_b);

   always_comb begin
      data_in.ctrl   = in_data.ctrl;
      data_in.a      = in_data.a;
      data_in.c0     = in_data.c0;
      data_in.prod_r = PROD_W'(in_data.r) * 14'd19;
      data_in.prod_g = PROD_W'(in_data.g) * 14'd38;
      data_in.prod_b = PROD_W'(in_data.b) * 14'd7;
      if (in_data.ctrl.is_yuv) begin
         data_in.r = shift_clamp(sum_r);
         data_in.g = shift_clamp(sum_g);
         data_in.b = shift_clamp(sum_b);
      end else begin
         data_in.r = in_data.r;
         data_in.g = in_data.g;
         data_in.b = in_data.b;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/pfc_pack.sv =====
// ----------------------------------------------------------------------------
// pfc_pack: third pipeline stage and output register
// Finishes the gray sum and packs bytes in destination channel order.
// ----------------------------------------------------------------------------
module pfc_pack (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  pfc_pkg::s2_type    in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         out0,
   output logic [7:0]         out1,
   output logic [7:0]         out2,
   output logic [7:0]         out3,
   output logic [2:0]         out_channels,
   output logic               bad_pair,
   output logic               last_out
);
   import pfc_pkg::*;

   logic              valid_ff, valid_in;
   logic [PROD_W-1:0] gray_sum;
   logic [PIX_W-1:0]  gray;
   logic [PIX_W-1:0]  o0_in, o1_in, o2_in, o3_in;
   logic [PIX_W-1:0]  o0_ff, o1_ff, o2_ff, o3_ff;
   logic [CNT_W-1:0]  chan_ff;
   logic              bad_ff, last_ff;

   // weights sum to 64, so the sum never exceeds 64 * 255
   assign gray_sum = in_data.prod_r + in_data.prod_g + in_data.prod_b;
   assign gray     = in_data.ctrl.gray_copy ? in_data.c0 : gray_sum[PROD_W-1:6];

   always_comb begin
      o0_in = '0; o1_in = '0; o2_in = '0; o3_in = '0;
      if (in_data.ctrl.ok) begin
         unique case (in_data.ctrl.dst)
            FMT_RGBA: begin
               o0_in = in_data.r; o1_in = in_data.g; o2_in = in_data.b;
               o3_in = in_data.a;
            end
            FMT_BGRA: begin
               o0_in = in_data.b; o1_in = in_data.g; o2_in = in_data.r;
               o3_in = in_data.a;
            end
            FMT_RGB: begin
               o0_in = in_data.r; o1_in = in_data.g; o2_in = in_data.b;
            end
            FMT_BGR: begin
               o0_in = in_data.b; o1_in = in_data.g; o2_in = in_data.r;
            end
            FMT_GRAY: o0_in = gray;
            default:  o0_in = '0;
         endcase
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         o0_ff   <= o0_in;
         o1_ff   <= o1_in;
         o2_ff   <= o2_in;
         o3_ff   <= o3_in;
         chan_ff <= in_data.ctrl.channels;
         bad_ff  <= !in_data.ctrl.ok;
         last_ff <= in_data.ctrl.last;
      end
   end

   assign out_valid    = valid_ff;
   assign out0         = o0_ff;
   assign out1         = o1_ff;
   assign out2         = o2_ff;
   assign out3         = o3_ff;
   assign out_channels = chan_ff;
   assign bad_pair     = bad_ff;
   assign last_out     = last_ff;

endmodule

// ===== rtl/pixel_format_converter.sv =====
// ----------------------------------------------------------------------------
// pixel_format_converter: packed pixel format and colour-space converter
// Converts one pixel per request between RGBA, BGRA, RGB, BGR, gray and YUV
// source formats and RGBA, BGRA, RGB, BGR and gray destination formats.
// ----------------------------------------------------------------------------
// The converter takes one pixel request per clock cycle while the response
// side does not stall, and returns one response per request, in order, each
// from the output register. It is a three-stage pipeline: unpack and
// chroma products, luma/chroma sum with shift and clamp (or gray weighting
// products), then gray sum and packing into the output register. Each stage
// carries its own valid bit and a stage advances whenever the stage after it
// is empty or moving, so a full pipeline keeps streaming at one pixel per
// cycle while rsp_ready stays high, and req_ready drops only when all three
// stages hold a pixel and the response is not taken. The formats are chosen
// by two registers written through the csr_ port (index 0 source format,
// index 1 destination format; csr_ready is always high). Write them only
// while no request is in flight. Unsupported pairs give zero bytes, a zero
// channel count and bad_pair set; last_out always follows last_pixel.
// ----------------------------------------------------------------------------
module pixel_format_converter (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [2:0] csr_data,
   // pixel requests
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_chan0,
   input  logic [7:0] req_chan1,
   input  logic [7:0] req_chan2,
   input  logic [7:0] req_chan3,
   input  logic       req_last_pixel,
   // pixel responses
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out0,
   output logic [7:0] rsp_out1,
   output logic [7:0] rsp_out2,
   output logic [7:0] rsp_out3,
   output logic [2:0] rsp_out_channels,
   output logic       rsp_bad_pair,
   output logic       rsp_last_out
);
   import pfc_pkg::*;

   logic [FMT_W-1:0] src_format_ff, src_format_in;
   logic [FMT_W-1:0] dst_format_ff, dst_format_in;

   logic   s1_valid, s1_ready;
   s1_type s1_data;
   logic   s2_valid, s2_ready;
   s2_type s2_data;

   // Configuration registers: always accept a write.
   assign csr_ready = 1'b1;

   always_comb begin
      src_format_in = src_format_ff;
      dst_format_in = dst_format_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SRC_FORMAT: src_format_in = csr_data;
            CSR_DST_FORMAT: dst_format_in = csr_data;
            default:        src_format_in = src_format_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_format_ff <= FMT_RGBA;
         dst_format_ff <= FMT_RGBA;
      end else begin
         src_format_ff <= src_format_in;
         dst_format_ff <= dst_format_in;
      end
   end

   // Stage 1: decode the pair, unpack the bytes, form chroma products.
   pfc_unpack u_unpack (
      .clock      (clock),
      .reset      (reset),
      .src_format (src_format_ff),
      .dst_format (dst_format_ff),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .chan0      (req_chan0),
      .chan1      (req_chan1),
      .chan2      (req_chan2),
      .chan3      (req_chan3),
      .last_pixel (req_last_pixel),
      .out_valid  (s1_valid),
      .out_ready  (s1_ready),
      .out_data   (s1_data)
   );

   // Stage 2: sum, shift and clamp YUV; weight colour bytes for gray.
   pfc_colour u_colour (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   // Stage 3: finish gray, pack in destination order, hold the response.
   pfc_pack u_pack (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s2_valid),
      .in_ready     (s2_ready),
      .in_data      (s2_data),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out0         (rsp_out0),
      .out1         (rsp_out1),
      .out2         (rsp_out2),
      .out3         (rsp_out3),
      .out_channels (rsp_out_channels),
      .bad_pair     (rsp_bad_pair),
      .last_out     (rsp_last_out)
   );

`ifndef NO_ASSERTIONS
   // An error response carries no bytes and no channel count.
   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_pair |->
         rsp_out_channels == 3'd0 && rsp_out0 == 8'd0 && rsp_out1 == 8'd0 &&
         rsp_out2 == 8'd0 && rsp_out3 == 8'd0)
      else $error("error response with non-zero payload");

   // A good response always reports 1, 3 or 4 bytes.
   a_good_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_pair |->
         rsp_out_channels == 3'd1 || rsp_out_channels == 3'd3 ||
         rsp_out_channels == 3'd4)
      else $error("good response with bad channel count");

   // Unused bytes of gray and three-channel output are zero.
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_channels == 3'd1 || rsp_out_channels == 3'd3) |->
         rsp_out3 == 8'd0 &&
         (rsp_out_channels == 3'd3 || (rsp_out1 == 8'd0 && rsp_out2 == 8'd0)))
      else $error("unused output byte not zero");

   // Back-pressure reaches the request side only when every stage is full.
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid && s2_valid && rsp_valid && !rsp_ready)
      else $error("request stalled with room in the pipeline");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the pixel format converter
// Streams pixels through every source/destination format pair, including
// the unsupported ones, with random gaps on both sides and random
// back-pressure. An in-bench colour conversion model predicts each response,
// and a checker compares it field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pfc_pkg::*;

   // Cycles in a row with no handshake on any channel before the run is
   // abandoned. In a correct run, gaps and stalls are short random runs and
   // the pipeline is 3 deep.
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;
   localparam int IDLE_PERCENT = 14;

   // One predicted response, in the order of the response ports
   typedef struct packed {
      logic [7:0] out0;
      logic [7:0] out1;
      logic [7:0] out2;
      logic [7:0] out3;
      logic [2:0] channels;
      logic       bad_pair;
      logic       last;
   } pixel_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = CSR_SRC_FORMAT;
   logic [2:0] csr_data = '0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_chan0 = '0;
   logic [7:0] req_chan1 = '0;
   logic [7:0] req_chan2 = '0;
   logic [7:0] req_chan3 = '0;
   logic       req_last_pixel = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out0;
   logic [7:0] rsp_out1;
   logic [7:0] rsp_out2;
   logic [7:0] rsp_out3;
   logic [2:0] rsp_out_channels;
   logic       rsp_bad_pair;
   logic       rsp_last_out;

   // Formats as the block holds them, tracked at each register write
   logic [2:0] src_fmt = FMT_RGBA;
   logic [2:0] dst_fmt = FMT_RGBA;

   pixel_result_type pending_pixels[$];
   int               mismatch_count = 0;
   int               stall_cycles = 0;
   int               pixels_sent = 0;
   bit               steady_flow = 1'b0;   // set: no gaps and no back-pressure

   pixel_format_converter i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_chan0        (req_chan0),
      .req_chan1        (req_chan1),
      .req_chan2        (req_chan2),
      .req_chan3        (req_chan3),
      .req_last_pixel   (req_last_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out0         (rsp_out0),
      .rsp_out1         (rsp_out1),
      .rsp_out2         (rsp_out2),
      .rsp_out3         (rsp_out3),
      .rsp_out_channels (rsp_out_channels),
      .rsp_bad_pair     (rsp_bad_pair),
      .rsp_last_out     (rsp_last_out)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Colour conversion model
   // ------------------------------------------------------------------------

   // Floor-divide by 64 (arithmetic shift) and saturate to one byte
   function automatic int clamp_byte(input int x);
      int q;
      q = x >>> 6;
      if (q < 0) begin
         return 0;
      end else if (q > 255) begin
         return 255;
      end
      return q;
   endfunction

   function automatic pixel_result_type convert_pixel(
      input logic [2:0] src, input logic [2:0] dst,
      input logic [7:0] c0, input logic [7:0] c1,
      input logic [7:0] c2, input logic [7:0] c3,
      input logic last);
      logic [7:0]       r, g, b, a;
      int               y, u, v, luma;
      bit               four_in, ok;
      pixel_result_type res;
      r = '0;
      g = '0;
      b = '0;
      a = '0;
      four_in = 1'b0;
      ok = 1'b1;
      res = '0;
      // unpack into R, G, B and alpha
      case (src)
         FMT_RGBA: begin
            r = c0; g = c1; b = c2; a = c3; four_in = 1'b1;
         end
         FMT_BGRA: begin
            r = c2; g = c1; b = c0; a = c3; four_in = 1'b1;
         end
         FMT_RGB: begin
            r = c0; g = c1; b = c2;
         end
         FMT_BGR: begin
            r = c2; g = c1; b = c0;
         end
         FMT_GRAY: begin
            r = c0; g = c0; b = c0; a = ALPHA_OPAQUE; four_in = 1'b1;
         end
         FMT_YUV: begin
            // chan0 = Y, chan1 = V, chan2 = U; chroma centred on 128
            y = int'(c0) * 64;
            v = int'(c1) - 128;
            u = int'(c2) - 128;
            r = 8'(clamp_byte(y + 73 * v));
            g = 8'(clamp_byte(y - 25 * u - 37 * v));
            b = 8'(clamp_byte(y + 130 * u));
            a = ALPHA_OPAQUE;
            four_in = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      // pack into the destination order
      if (ok) begin
         case (dst)
            FMT_RGBA: begin
               if (!four_in) begin
                  ok = 1'b0;
               end else begin
                  res.out0 = r; res.out1 = g; res.out2 = b; res.out3 = a;
                  res.channels = 3'd4;
               end
            end
            FMT_BGRA: begin
               if (!four_in) begin
                  ok = 1'b0;
               end else begin
                  res.out0 = b; res.out1 = g; res.out2 = r; res.out3 = a;
                  res.channels = 3'd4;
               end
            end
            FMT_RGB: begin
               res.out0 = r; res.out1 = g; res.out2 = b; res.channels = 3'd3;
            end
            FMT_BGR: begin
               res.out0 = b; res.out1 = g; res.out2 = r; res.channels = 3'd3;
            end
            FMT_GRAY: begin
               // gray and luma pass straight through; colour is weighted
               luma = (19 * r + 38 * g + 7 * b) >> 6;
               res.out0 = (src == FMT_GRAY || src == FMT_YUV) ? c0 : luma[7:0];
               res.channels = 3'd1;
            end
            default: begin
               ok = 1'b0;
            end
         endcase
      end
      if (!ok) begin
         res = '0;
      end
      res.bad_pair = !ok;
      res.last = last;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // Bias towards the byte extremes and the chroma midpoint
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd128;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Offer one pixel request, with a random gap first, and hold it until taken.
   // Valid is left high afterwards so that back-to-back requests stream.
   task automatic send_pixel(input logic [7:0] c0, input logic [7:0] c1,
                             input logic [7:0] c2, input logic [7:0] c3,
                             input logic last);
      @(negedge clock);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_chan0 <= c0;
      req_chan1 <= c1;
      req_chan2 <= c2;
      req_chan3 <= c3;
      req_last_pixel <= last;
      do begin
         @(posedge clock);
      end while (!req_ready);
      pending_pixels.push_back(convert_pixel(src_fmt, dst_fmt, c0, c1, c2, c3, last));
      pixels_sent++;
   endtask

   task automatic send_random_pixel();
      send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(), $urandom_range(7) == 0);
   endtask

   // Drop valid and wait until every predicted response has been checked
   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Write one format register; call only with the pipeline drained
   task automatic write_format(input csr_index_type which, input logic [2:0] code);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data <= code;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      if (which == CSR_SRC_FORMAT) begin
         src_fmt = code;
      end else begin
         dst_fmt = code;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic select_formats(input logic [2:0] src, input logic [2:0] dst);
      drain_pipeline();
      write_format(CSR_SRC_FORMAT, src);
      write_format(CSR_DST_FORMAT, dst);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Both registers come out of reset as RGBA: expect a straight copy
   task automatic test_reset_formats();
      send_pixel(8'd0, 8'd255, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd255, 8'd0, 1'b1);
   endtask

   // Luma and chroma at their extremes: clamping at both ends and neutral grey
   task automatic test_yuv_extremes();
      select_formats(FMT_YUV, FMT_RGBA);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd128, 8'd128, 8'd128, 8'd0, 1'b0);
      send_pixel(8'd16, 8'd128, 8'd128, 8'd77, 1'b1);
      select_formats(FMT_YUV, FMT_GRAY);
      send_pixel(8'd200, 8'd0, 8'd255, 8'd0, 1'b1);
   endtask

   // Weighted gray from colour, gray expansion to four channels
   task automatic test_gray_paths();
      select_formats(FMT_RGBA, FMT_GRAY);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
      select_formats(FMT_GRAY, FMT_BGRA);
      send_pixel(8'd255, 8'd1, 8'd2, 8'd3, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd255, 8'd255, 1'b1);
   endtask

   // Unsupported pairs: zero bytes and bad_pair, last_out still follows
   task automatic test_unsupported_pairs();
      select_formats(FMT_RGB, FMT_RGBA);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      select_formats(3'd7, FMT_RGBA);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
      select_formats(FMT_RGBA, 3'd7);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      select_formats(3'd6, 3'd5);
      send_pixel(8'd1, 8'd2, 8'd3, 8'd4, 1'b1);
   endtask

   // Every register code against every other, a short burst each
   task automatic test_all_pairs();
      for (int s = 0; s < 8; s++) begin
         for (int d = 0; d < 8; d++) begin
            select_formats(3'(s), 3'(d));
            repeat (12) send_random_pixel();
         end
      end
   endtask

   // One long stream with no gaps and no back-pressure
   task automatic test_back_to_back();
      select_formats(FMT_YUV, FMT_BGRA);
      steady_flow = 1'b1;
      repeat (300) send_random_pixel();
      steady_flow = 1'b0;
   endtask

   // Random format changes, sometimes of one register only, between bursts
   task automatic test_random_streams();
      int target;
      target = pixels_sent + 380;
      while (pixels_sent < target) begin
         drain_pipeline();
         if ($urandom_range(3) != 0) begin
            write_format(CSR_SRC_FORMAT,
                         ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6))
                                                  : 3'($urandom_range(5)));
         end
         if ($urandom_range(3) != 0) begin
            write_format(CSR_DST_FORMAT,
                         ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                                                  : 3'($urandom_range(4)));
         end
         repeat ($urandom_range(4, 60)) send_random_pixel();
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side: random back-pressure, checking, watchdog
   // ------------------------------------------------------------------------

   always @(negedge clock) begin
      rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin : check_response
      pixel_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("%0t: response with no request outstanding", $realtime);
            end
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_out0 !== want.out0 || rsp_out1 !== want.out1 ||
                rsp_out2 !== want.out2 || rsp_out3 !== want.out3 ||
                rsp_out_channels !== want.channels || rsp_bad_pair !== want.bad_pair ||
                rsp_last_out !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: mismatch, expected %h %h %h %h ch=%0d bad=%b last=%b",
                           $realtime, want.out0, want.out1, want.out2, want.out3,
                           want.channels, want.bad_pair, want.last);
                  $display("%0t:             actual %h %h %h %h ch=%0d bad=%b last=%b",
                           $realtime, rsp_out0, rsp_out1, rsp_out2, rsp_out3,
                           rsp_out_channels, rsp_bad_pair, rsp_last_out);
               end
            end
         end
      end
   end

   // Count cycles in which no channel moves anything
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("testbench NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      // hold reset, then release it on a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_formats();
      test_yuv_extremes();
      test_gray_paths();
      test_unsupported_pairs();
      test_all_pairs();
      test_back_to_back();
      test_random_streams();

      // let the last responses out, then watch for strays
      drain_pipeline();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ===== pixel_format_converter.f =====
rtl/pfc_pkg.sv
rtl/pfc_unpack.sv
rtl/pfc_colour.sv
rtl/pfc_pack.sv
rtl/pixel_format_converter.sv
tb/testbench.sv
